FILE: sv/jts_pkg.sv
// Package for the job tick scheduler: beat structs, policy codes, sequencer states
// and configuration register indexes. No dependencies.
package jts_pkg;

  // Largest batch the store is sized for by default.
  localparam int unsigned MAX_JOBS_DEF = 8;

  // Field widths fixed by the beat formats.
  localparam int unsigned BURST_W = 3;
  localparam int unsigned PRIO_W  = 3;
  localparam int unsigned ID_W    = 3;
  localparam int unsigned QUANT_W = 3;
  localparam int unsigned MODE_W  = 2;

  // Reset values of the configuration registers.
  localparam logic [QUANT_W-1:0] QUANTUM_RST = 3'd2;

  // Configuration register indexes.
  localparam logic CFG_IDX_MODE    = 1'b0;
  localparam logic CFG_IDX_QUANTUM = 1'b1;

  // Scheduling policies.
  typedef enum logic [MODE_W-1:0] {
    POL_FCFS = 2'd0,
    POL_SJF  = 2'd1,
    POL_PRIO = 2'd2,
    POL_RR   = 2'd3
  } policy_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PICK  = 2'd1,
    ST_SHIFT = 2'd2,
    ST_RUN   = 2'd3
  } state_t;

  // One input beat: a job to load.
  typedef struct packed {
    logic [BURST_W-1:0] burst_length;
    logic [PRIO_W-1:0]  job_priority;
    logic               last_job;
  } in_item_t;

  // One result beat: a single tick.
  typedef struct packed {
    logic [ID_W-1:0]    job_id;
    logic [BURST_W-1:0] remaining_before;
    logic               last_tick;
  } out_item_t;

endpackage

FILE: sv/jts_out_stage.sv
// Output register of the job tick scheduler: holds one result beat until taken.
// Depends on jts_pkg for the result beat struct.
module jts_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  jts_pkg::out_item_t push_data,
  output logic               slot_free,
  output logic               out_valid,
  input  logic               out_stall,
  output jts_pkg::out_item_t out_data
);

  logic               valid_r;
  logic               valid_nxt;
  jts_pkg::out_item_t data_r;

  // The slot can take a new beat when empty or when its beat leaves this cycle.
  assign slot_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (push_valid) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload is loaded only on a push, so a stalled beat holds.
  always_ff @(posedge clk) begin
    if (push_valid) begin
      data_r <= push_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: sv/jts_core.sv
// Sequencer and job store of the job tick scheduler: loads jobs, sorts the run
// order one compare per cycle and walks the ticks. Depends on jts_pkg.
module jts_core #(
  parameter int unsigned MAX_JOBS = jts_pkg::MAX_JOBS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  jts_pkg::in_item_t             in_data,
  input  jts_pkg::policy_t              policy,
  input  logic [jts_pkg::QUANT_W-1:0]   quantum,
  input  logic                          slot_free,
  output logic                          tick_valid,
  output jts_pkg::out_item_t            tick_data
);

  localparam int unsigned JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam int unsigned TW = $clog2(MAX_JOBS * 7 + 1);
  localparam int unsigned BW = jts_pkg::BURST_W;
  localparam int unsigned QW = jts_pkg::QUANT_W;

  // Job store, one entry per loaded job.
  logic [BW-1:0] burst_mem [MAX_JOBS];
  logic [BW-1:0] prio_mem  [MAX_JOBS];
  logic [BW-1:0] rem_mem   [MAX_JOBS];
  logic [JW-1:0] order_mem [MAX_JOBS];

  jts_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [TW-1:0]   total_r, total_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [JW-1:0]   v_r, v_nxt;
  logic [BW-1:0]   vkey_r, vkey_nxt;
  logic [JW-1:0]   pos_r, pos_nxt;
  logic [QW-1:0]   k_r, k_nxt;

  logic          accept;
  logic          store_ok;
  logic          load_we;
  logic          sort_mode;
  logic          rr_mode;
  logic [QW-1:0] q_eff;
  logic [JW-1:0] ord_raddr;
  logic [JW-1:0] ord_rd;
  logic [BW-1:0] key_rd;
  logic [BW-1:0] rem_rd;
  logic          ord_we;
  logic [JW-1:0] ord_waddr;
  logic [JW-1:0] ord_wdata;
  logic          rem_we;
  logic          turn_done;
  logic          emit;

  // Input side and mode decode.
  assign in_stall  = (state_r != jts_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign store_ok  = (cnt_r < CW'(MAX_JOBS));
  assign load_we   = accept && store_ok;
  assign sort_mode = (policy == jts_pkg::POL_SJF) || (policy == jts_pkg::POL_PRIO);
  assign rr_mode   = (policy == jts_pkg::POL_RR);
  assign q_eff     = (quantum == '0) ? QW'(1) : quantum;

  // Single read port on the run order, shared by the sort and the tick walk.
  always_comb begin
    case (state_r)
      jts_pkg::ST_PICK:  ord_raddr = i_r[JW-1:0];
      jts_pkg::ST_SHIFT: ord_raddr = JW'(j_r - CW'(1));
      default:           ord_raddr = pos_r;
    endcase
  end

  assign ord_rd = order_mem[ord_raddr];
  assign key_rd = (policy == jts_pkg::POL_SJF) ? burst_mem[ord_rd] : prio_mem[ord_rd];
  assign rem_rd = rem_mem[ord_rd];

  // Tick walk: a turn ends when the job is done or, in round robin mode, its quantum is used up.
  assign turn_done = (rem_rd == '0) || (rr_mode && (k_r == q_eff));
  assign emit = (state_r == jts_pkg::ST_RUN) && (total_r != '0) && !turn_done && slot_free;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      jts_pkg::ST_IDLE: begin
        if (accept && in_data.last_job) begin
          state_nxt = sort_mode ? jts_pkg::ST_PICK : jts_pkg::ST_RUN;
        end
      end
      jts_pkg::ST_PICK: begin
        if (i_r == n_r) begin
          state_nxt = jts_pkg::ST_RUN;
        end else begin
          state_nxt = jts_pkg::ST_SHIFT;
        end
      end
      jts_pkg::ST_SHIFT: begin
        if ((j_r == '0) || (key_rd <= vkey_r)) begin
          state_nxt = jts_pkg::ST_PICK;
        end
      end
      jts_pkg::ST_RUN: begin
        if ((total_r == '0) || (emit && (total_r == TW'(1)))) begin
          state_nxt = jts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = jts_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls and counters.
  always_comb begin
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    total_nxt = total_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    v_nxt     = v_r;
    vkey_nxt  = vkey_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    ord_we    = 1'b0;
    ord_waddr = cnt_r[JW-1:0];
    ord_wdata = cnt_r[JW-1:0];
    rem_we    = 1'b0;
    case (state_r)
      jts_pkg::ST_IDLE: begin
        if (accept) begin
          if (store_ok) begin
            cnt_nxt   = cnt_r + CW'(1);
            total_nxt = total_r + TW'(in_data.burst_length);
            ord_we    = 1'b1;
          end
          if (in_data.last_job) begin
            n_nxt   = store_ok ? cnt_r + CW'(1) : cnt_r;
            i_nxt   = CW'(1);
            pos_nxt = '0;
            k_nxt   = '0;
          end
        end
      end
      jts_pkg::ST_PICK: begin
        v_nxt    = ord_rd;
        vkey_nxt = key_rd;
        j_nxt    = i_r;
      end
      jts_pkg::ST_SHIFT: begin
        ord_we    = 1'b1;
        ord_waddr = j_r[JW-1:0];
        if ((j_r != '0) && (key_rd > vkey_r)) begin
          ord_wdata = ord_rd;
          j_nxt     = j_r - CW'(1);
        end else begin
          ord_wdata = v_r;
          i_nxt     = i_r + CW'(1);
        end
      end
      jts_pkg::ST_RUN: begin
        if (total_r == '0) begin
          cnt_nxt = '0;
        end else if (turn_done) begin
          k_nxt   = '0;
          pos_nxt = ((CW'(pos_r) + CW'(1)) == n_r) ? '0 : pos_r + JW'(1);
        end else if (slot_free) begin
          rem_we    = 1'b1;
          total_nxt = total_r - TW'(1);
          k_nxt     = k_r + QW'(1);
          if (total_r == TW'(1)) begin
            cnt_nxt = '0;
          end
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // Result beat for the current tick.
  assign tick_valid = emit;
  always_comb begin
    tick_data.job_id           = jts_pkg::ID_W'(ord_rd);
    tick_data.remaining_before = rem_rd;
    tick_data.last_tick        = (total_r == TW'(1));
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jts_pkg::ST_IDLE;
      cnt_r   <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
    end
  end

  // Walk registers, set up before use.
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    v_r    <= v_nxt;
    vkey_r <= vkey_nxt;
    pos_r  <= pos_nxt;
    k_r    <= k_nxt;
  end

  // Job store writes: loading fills all four arrays at the fill count.
  always_ff @(posedge clk) begin
    if (load_we) begin
      burst_mem[cnt_r[JW-1:0]] <= in_data.burst_length;
      prio_mem[cnt_r[JW-1:0]]  <= in_data.job_priority;
    end
    if (ord_we) begin
      order_mem[ord_waddr] <= ord_wdata;
    end
    if (load_we) begin
      rem_mem[cnt_r[JW-1:0]] <= in_data.burst_length;
    end else if (rem_we) begin
      rem_mem[ord_rd] <= rem_rd - BW'(1);
    end
  end

`ifndef SYNTH
  // A tick never reports a finished job.
  a_tick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (rem_rd != '0))
    else $error("tick issued for a job with no remaining burst");

  // The final tick of a run returns the block to loading.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && tick_data.last_tick) |=> (state_r == jts_pkg::ST_IDLE))
    else $error("run did not end after its final tick");

  // A run with no work left ends at once and empties the batch.
  a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == jts_pkg::ST_RUN) && (total_r == '0))
      |=> ((state_r == jts_pkg::ST_IDLE) && (cnt_r == '0)))
    else $error("empty run did not return to idle");

  // While sorting or running the batch is never empty.
  a_batch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != jts_pkg::ST_IDLE) |-> (n_r != '0))
    else $error("sequencer busy with an empty batch");
`endif

endmodule

FILE: sv/job_tick_scheduler.sv
// Job tick scheduler: one CPU serving a batch of jobs under a selectable policy.
// Top level with the configuration registers; depends on jts_pkg, jts_core and
// jts_out_stage.
//
// Usage: each input beat loads one job (burst length, priority); jobs are numbered
// by load order. A beat with last_job set is stored as well and starts the run.
// Beats beyond MAX_JOBS jobs are dropped, but a dropped beat marked last still
// starts the run. After the last beat, the shortest job first and priority modes
// sort the run order with one compare per cycle. The tick walk then issues one
// result beat per cycle while the result channel is not stalled, apart from a step
// each time the walk moves to the next job; result beat last_tick marks the final
// tick. The input is stalled from the last beat until the final tick has entered
// the output register. A stall on the result channel holds the output register
// and pauses the walk; nothing is lost. Reset clears the batch and the output
// register and sets the policy to first come first served and the quantum to 2.
// Configuration writes are always ready and are meant for idle periods only.
module job_tick_scheduler #(
  parameter int unsigned MAX_JOBS = jts_pkg::MAX_JOBS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  jts_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output jts_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [jts_pkg::QUANT_W-1:0] cfg_data
);

  jts_pkg::policy_t              policy_r;
  logic [jts_pkg::QUANT_W-1:0]   quantum_r;
  logic                          slot_free;
  logic                          tick_valid;
  jts_pkg::out_item_t            tick_data;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= jts_pkg::POL_FCFS;
      quantum_r <= jts_pkg::QUANTUM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jts_pkg::CFG_IDX_MODE:    policy_r  <= jts_pkg::policy_t'(cfg_data[jts_pkg::MODE_W-1:0]);
        jts_pkg::CFG_IDX_QUANTUM: quantum_r <= cfg_data;
        default:                  policy_r  <= policy_r;
      endcase
    end
  end

  // Sequencer and job store.
  jts_core #(
    .MAX_JOBS (MAX_JOBS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .policy     (policy_r),
    .quantum    (quantum_r),
    .slot_free  (slot_free),
    .tick_valid (tick_valid),
    .tick_data  (tick_data)
  );

  // Output register.
  jts_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (tick_valid),
    .push_data  (tick_data),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
